@@ hw/rtl/first_fit_segment_allocator_top_macros.svh @@
// ----------------------------------------------------------------------------
// first_fit_segment_allocator_top_macros
// Assertion macros for the segment allocator.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_SEGMENT_ALLOCATOR_TOP_MACROS_SVH
`define FIRST_FIT_SEGMENT_ALLOCATOR_TOP_MACROS_SVH
// Implication checked at every clock edge outside reset.
`define FFSA_ASSERT_IMP(label, clk, rst_n, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
// Next-cycle implication checked outside reset.
`define FFSA_ASSERT_NXT(label, clk, rst_n, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`endif

@@ hw/rtl/ffsa_pkg.sv @@
// ----------------------------------------------------------------------------
// ffsa_pkg
// Shared types and constants of the first-fit segment allocator.
// ----------------------------------------------------------------------------
package ffsa_pkg;
  localparam int MAX_SEGMENTS_DEF = 16;
  localparam int HEADER_BYTES_DEF = 16;
  localparam logic [31:0] RESET_BASE = 32'h0400_0000;
  localparam logic [31:0] RESET_END = 32'h0800_0000;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NOFIT = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_BADH = 2'd3;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE = 1'b1;

  localparam logic REG_BASE = 1'b0;
  localparam logic REG_END = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_DECIDE, S_SHIFT, S_DONE
  } state_t;

  // Shift operations over the table.
  typedef enum logic [1:0] {
    SH_NONE, SH_INSERT, SH_REMOVE
  } shift_t;

  // Controller commands to the datapath.
  typedef struct packed {
    logic   load;      // capture the request, reset scan index
    logic   step;      // advance scan index
    logic   decide;    // evaluate the found entry, plan updates
    logic   shift;     // perform one shift step
    logic   finish;    // present the result
  } ctl_t;

  // Datapath status back to the controller.
  typedef struct packed {
    logic   scan_end;  // index at last entry or match found
    logic   need_shift;
    logic   shift_end;
  } sts_t;
endpackage

@@ hw/rtl/first_fit_segment_allocator_top.sv @@
// ----------------------------------------------------------------------------
// first_fit_segment_allocator_top
// First-fit allocator with split and coalescing over one address region.
// ----------------------------------------------------------------------------
// A request enters on the in_ channel (cmd, request_size, block_address) and
// its single result leaves on the out_ channel (status, granted_address,
// data_start). One request is handled at a time. The scan walks the table
// entry by entry until it stops, then the request is decided; a split
// insert or a merge removal then moves table entries in the shift engine,
// with one more step per insert or removal pass, before the result is
// presented. The scan visits one table entry per cycle and the shift engine
// moves one entry per cycle. The result is held in an output register
// until out_ready takes it; the next request is taken the cycle after that
// register is freed. Reset (rst_n, low, synchronous) restores region_base
// 0x04000000, region_end 0x08000000 and a table of one free segment. Writing
// either register through the cfg_ port re-initializes the table. Writes
// come only while idle; the user must keep to this, unenforced by the block.
// ----------------------------------------------------------------------------
`include "first_fit_segment_allocator_top_macros.svh"
module first_fit_segment_allocator_top #(
  parameter int MAX_SEGMENTS = ffsa_pkg::MAX_SEGMENTS_DEF,
  parameter int HEADER_BYTES = ffsa_pkg::HEADER_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_cmd,
  input  logic [27:0] in_request_size,
  input  logic [31:0] in_block_address,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [31:0] out_granted_address,
  output logic [31:0] out_data_start,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  ffsa_pkg::ctl_t ctl;
  ffsa_pkg::sts_t sts;
  logic [31:0] base_r, end_r;
  logic wr, init;

  // Configuration registers.
  assign cfg_pready = 1'b1;
  assign wr = cfg_psel && cfg_penable && cfg_pwrite;
  assign init = wr && (cfg_paddr[1:0] == 2'd0);
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= ffsa_pkg::RESET_BASE;
      end_r <= ffsa_pkg::RESET_END;
    end else if (init) begin
      if (cfg_paddr[2] == ffsa_pkg::REG_BASE) base_r <= cfg_pwdata;
      else end_r <= cfg_pwdata;
    end
  end
  // Register index lives in paddr bit 2; paddr 4 selects region_end.
  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr == 3'd0) cfg_prdata = base_r;
    else if (cfg_paddr == 3'd4) cfg_prdata = end_r;
  end

  ffsa_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .sts(sts), .ctl(ctl)
  );

  ffsa_dp #(.MAX_SEGMENTS(MAX_SEGMENTS), .HEADER_BYTES(HEADER_BYTES)) u_dp (
    .clk(clk), .rst_n(rst_n), .ctl(ctl), .sts(sts), .init(init),
    .region_base(cfg_paddr[2] == ffsa_pkg::REG_BASE ? cfg_pwdata : base_r),
    .region_end(end_r),
    .in_cmd(in_cmd), .in_request_size(in_request_size),
    .in_block_address(in_block_address), .out_status(out_status),
    .out_granted_address(out_granted_address), .out_data_start(out_data_start)
  );

  // A new request is never taken while a result waits.
  `FFSA_ASSERT_IMP(a_no_accept_busy, clk, rst_n, in_ready, !out_valid, "accept while result pending")
  // A failed request reports no address.
  `FFSA_ASSERT_IMP(a_fail_zero, clk, rst_n, out_valid && out_status != ffsa_pkg::ST_OK, out_granted_address == '0, "address on failure")
  // Results appear only after a completed request.
  `FFSA_ASSERT_NXT(a_finish_valid, clk, rst_n, ctl.finish, out_valid, "finish without result")
endmodule

@@ hw/rtl/ffsa_ctrl.sv @@
// ----------------------------------------------------------------------------
// ffsa_ctrl
// Sequencer for scan, decision, table shift and result hand-off.
// ----------------------------------------------------------------------------
module ffsa_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  ffsa_pkg::sts_t  sts,
  output ffsa_pkg::ctl_t  ctl
);
  ffsa_pkg::state_t state_r, state_nxt;
  logic ov_r, ov_nxt;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ffsa_pkg::S_IDLE: if (in_valid && !ov_r) state_nxt = ffsa_pkg::S_SCAN;
      ffsa_pkg::S_SCAN: if (sts.scan_end) state_nxt = ffsa_pkg::S_DECIDE;
      ffsa_pkg::S_DECIDE: state_nxt = sts.need_shift ? ffsa_pkg::S_SHIFT : ffsa_pkg::S_DONE;
      ffsa_pkg::S_SHIFT: if (sts.shift_end) state_nxt = ffsa_pkg::S_DONE;
      ffsa_pkg::S_DONE: state_nxt = ffsa_pkg::S_IDLE;
      default: state_nxt = ffsa_pkg::S_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    ctl = '0;
    in_ready = 1'b0;
    case (state_r)
      ffsa_pkg::S_IDLE: begin
        in_ready = !ov_r;
        ctl.load = in_valid && !ov_r;
      end
      ffsa_pkg::S_SCAN: ctl.step = 1'b1;
      ffsa_pkg::S_DECIDE: ctl.decide = 1'b1;
      ffsa_pkg::S_SHIFT: ctl.shift = 1'b1;
      ffsa_pkg::S_DONE: ctl.finish = 1'b1;
      default: ctl = '0;
    endcase
  end

  // The result register stays valid until taken.
  always_comb begin
    ov_nxt = ov_r;
    if (out_ready) ov_nxt = 1'b0;
    if (ctl.finish) ov_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ffsa_pkg::S_IDLE;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r <= ov_nxt;
    end
  end

  assign out_valid = ov_r;
endmodule

@@ hw/rtl/ffsa_dp.sv @@
// ----------------------------------------------------------------------------
// ffsa_dp
// Segment table, scan comparator, shift engine and result registers.
// ----------------------------------------------------------------------------
module ffsa_dp #(
  parameter int MAX_SEGMENTS = ffsa_pkg::MAX_SEGMENTS_DEF,
  parameter int HEADER_BYTES = ffsa_pkg::HEADER_BYTES_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  ffsa_pkg::ctl_t  ctl,
  output ffsa_pkg::sts_t  sts,
  input  logic            init,
  input  logic [31:0]     region_base,
  input  logic [31:0]     region_end,
  input  logic            in_cmd,
  input  logic [27:0]     in_request_size,
  input  logic [31:0]     in_block_address,
  output logic [1:0]      out_status,
  output logic [31:0]     out_granted_address,
  output logic [31:0]     out_data_start
);
  localparam int IW = $clog2(MAX_SEGMENTS);
  localparam int CW = $clog2(MAX_SEGMENTS + 1);
  localparam logic [CW-1:0] CMAX = CW'(MAX_SEGMENTS);
  localparam logic [32:0] HB = 33'(HEADER_BYTES);

  // Table entries, read by the shift engine at its moving cursor.
  logic [31:0]       start_r [MAX_SEGMENTS];
  logic [MAX_SEGMENTS-1:0] used_r;
  logic [CW-1:0]     cnt_r;

  logic              cmd_r;
  logic [27:0]       size_r;
  logic [31:0]       addr_r;
  logic [CW-1:0]     idx_r;    // scan index
  logic              found_r;
  logic [CW-1:0]     hit_r;
  logic [CW-1:0]     sh_r;     // shift cursor
  logic [CW-1:0]     sh_stop_r;
  ffsa_pkg::shift_t  op_r;
  logic              second_r; // a second removal follows the first
  logic [CW-1:0]     second_i_r;
  logic [31:0]       ins_val_r;
  logic [1:0]        st_r;
  logic [31:0]       ga_r, ds_r;

  // Current scan entry and its span.
  logic [IW-1:0] ix;
  logic [31:0]   s_cur, e_cur;
  logic          is_last;
  logic [32:0]   span, need;
  logic          match;
  assign ix = idx_r[IW-1:0];
  assign s_cur = start_r[ix];
  assign is_last = (idx_r + 1'b1) >= cnt_r;
  assign e_cur = is_last ? region_end : start_r[IW'(idx_r + 1'b1)];
  assign span = (e_cur >= s_cur) ? {1'b0, e_cur - s_cur} : 33'd0;
  assign need = HB + {5'd0, size_r};
  assign match = (cmd_r == ffsa_pkg::CMD_ALLOC) ? (!used_r[ix] && span >= need)
                                              : (used_r[ix] && s_cur == addr_r);

  // Decision on the hit entry.
  logic [IW-1:0] hx;
  logic [31:0]   h_s, h_e;
  logic [32:0]   h_span, rest;
  logic          split, nxt_free, prv_free;
  assign hx = hit_r[IW-1:0];
  assign h_s = start_r[hx];
  assign h_e = ((hit_r + 1'b1) >= cnt_r) ? region_end : start_r[IW'(hit_r + 1'b1)];
  assign h_span = (h_e >= h_s) ? {1'b0, h_e - h_s} : 33'd0;
  assign rest = h_span - need;
  assign split = (rest != 33'd0) && (rest >= HB);
  assign nxt_free = ((hit_r + 1'b1) < cnt_r) && !used_r[IW'(hit_r + 1'b1)];
  assign prv_free = (hit_r != '0) && !used_r[IW'(hit_r - 1'b1)];

  always_comb begin
    sts.scan_end = match || is_last;
    sts.need_shift = 1'b0;
    if (found_r) begin
      if (cmd_r == ffsa_pkg::CMD_ALLOC) sts.need_shift = split && (cnt_r < CMAX);
      else sts.need_shift = nxt_free || prv_free;
    end
    sts.shift_end = (op_r == ffsa_pkg::SH_INSERT) ? (sh_r == sh_stop_r)
                  : ((sh_r + 1'b1 >= cnt_r) && !second_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n || init) begin
      start_r[0] <= init ? region_base : ffsa_pkg::RESET_BASE;
      used_r <= '0;
      cnt_r <= CW'(1);
    end else if (ctl.load) begin
      cmd_r <= in_cmd;
      size_r <= in_request_size;
      addr_r <= in_block_address;
      idx_r <= '0;
      found_r <= 1'b0;
    end else if (ctl.step) begin
      if (match) begin
        found_r <= 1'b1;
        hit_r <= idx_r;
      end else idx_r <= idx_r + 1'b1;
    end else if (ctl.decide) begin
      second_r <= 1'b0;
      op_r <= ffsa_pkg::SH_NONE;
      st_r <= ffsa_pkg::ST_OK;
      ga_r <= '0;
      ds_r <= '0;
      if (!found_r) begin
        st_r <= (cmd_r == ffsa_pkg::CMD_ALLOC) ? ffsa_pkg::ST_NOFIT : ffsa_pkg::ST_BADH;
      end else if (cmd_r == ffsa_pkg::CMD_ALLOC) begin
        if (split && cnt_r >= CMAX) st_r <= ffsa_pkg::ST_FULL;
        else begin
          used_r[hx] <= 1'b1;
          ga_r <= h_s;
          ds_r <= h_s + 32'(HEADER_BYTES);
          if (split) begin
            op_r <= ffsa_pkg::SH_INSERT;
            sh_r <= cnt_r;
            sh_stop_r <= hit_r + 1'b1;
            ins_val_r <= h_s + 32'(HEADER_BYTES) + {4'd0, size_r};
          end
        end
      end else begin
        used_r[hx] <= 1'b0;
        ga_r <= addr_r;
        op_r <= ffsa_pkg::SH_REMOVE;
        if (nxt_free) begin
          sh_r <= hit_r + 1'b1;
          second_r <= prv_free;
          second_i_r <= hit_r;
        end else sh_r <= hit_r;
      end
    end else if (ctl.shift) begin
      if (op_r == ffsa_pkg::SH_INSERT) begin
        // Move one entry up per cycle, then drop in the new start.
        if (sh_r == sh_stop_r) begin
          start_r[sh_r[IW-1:0]] <= ins_val_r;
          used_r[sh_r[IW-1:0]] <= 1'b0;
          cnt_r <= cnt_r + 1'b1;
        end else begin
          start_r[sh_r[IW-1:0]] <= start_r[IW'(sh_r - 1'b1)];
          used_r[sh_r[IW-1:0]] <= used_r[IW'(sh_r - 1'b1)];
          sh_r <= sh_r - 1'b1;
        end
      end else begin
        // Move one entry down per cycle; the last step drops the count.
        if (sh_r + 1'b1 >= cnt_r) begin
          cnt_r <= cnt_r - 1'b1;
          if (second_r) begin
            second_r <= 1'b0;
            sh_r <= second_i_r;
          end
        end else begin
          start_r[sh_r[IW-1:0]] <= start_r[IW'(sh_r + 1'b1)];
          used_r[sh_r[IW-1:0]] <= used_r[IW'(sh_r + 1'b1)];
          sh_r <= sh_r + 1'b1;
        end
      end
    end
  end

  // Result register, loaded as the request completes.
  always_ff @(posedge clk) begin
    if (ctl.finish) begin
      out_status <= st_r;
      out_granted_address <= ga_r;
      out_data_start <= ds_r;
    end
  end
endmodule

@@ test/first_fit_segment_allocator_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_segment_allocator_top_tb
// Self-checking bench for the first-fit segment allocator.
// ----------------------------------------------------------------------------
// A queue of pending requests feeds a clocked driver, and a clocked monitor
// compares each result with the oldest prediction. The predictor keeps its
// own segment table and region registers. The run walks through several
// region settings written over the APB port while the block is idle. Both
// channels idle at random, and there is one long result stall and there are
// pauses until all results have drained.
// ----------------------------------------------------------------------------
module first_fit_segment_allocator_top_tb;

  localparam int NSEG = ffsa_pkg::MAX_SEGMENTS_DEF;
  localparam int HDR = ffsa_pkg::HEADER_BYTES_DEF;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic        cmd;
    logic [27:0] size;
    logic [31:0] addr;
  } alloc_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] granted;
    logic [31:0] data;
  } alloc_rsp_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_cmd = ffsa_pkg::CMD_ALLOC;
  logic [27:0] in_request_size = '0;
  logic [31:0] in_block_address = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] out_status;
  logic [31:0] out_granted_address;
  logic [31:0] out_data_start;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [2:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  first_fit_segment_allocator_top dut (.*);

  always #4 clk = ~clk;

  // Predictor state.
  logic [31:0] mdl_base, mdl_end;
  logic [31:0] seg_start [NSEG];
  logic        seg_used [NSEG];
  int          seg_cnt;

  alloc_req_t pending_reqs[$];
  alloc_rsp_t expected_rsps[$];
  logic [31:0] live_blocks[$];
  int errors = 0;
  int cycles = 0;
  int stall_hold = 0;
  logic stall_start = 1'b0;

  function automatic void table_clear();
    for (int k = 0; k < NSEG; k++) begin
      seg_start[k] = '0;
      seg_used[k] = 1'b0;
    end
    seg_start[0] = mdl_base;
    seg_cnt = 1;
  endfunction

  function automatic logic [32:0] span(int i);
    logic [31:0] e;
    e = (i + 1 < seg_cnt) ? seg_start[i + 1] : mdl_end;
    return (e >= seg_start[i]) ? {1'b0, e - seg_start[i]} : 33'd0;
  endfunction

  function automatic void drop_entry(int i);
    for (int k = i; k + 1 < seg_cnt; k++) begin
      seg_start[k] = seg_start[k + 1];
      seg_used[k] = seg_used[k + 1];
    end
    seg_cnt--;
  endfunction

  // Works out the result of one request and updates the segment table.
  function automatic alloc_rsp_t predict_allocation(alloc_req_t r);
    alloc_rsp_t o;
    int i;
    logic [33:0] need, rest;
    bit hit;
    o = '0;
    hit = 0;
    if (r.cmd == ffsa_pkg::CMD_ALLOC) begin
      need = 34'(HDR) + {6'd0, r.size};
      for (i = 0; i < seg_cnt; i++) begin
        if (!seg_used[i] && span(i) >= need) begin
          hit = 1;
          break;
        end
      end
      if (!hit) begin
        o.status = ffsa_pkg::ST_NOFIT;
      end else begin
        rest = span(i) - need;
        if (rest != 0 && rest >= HDR && seg_cnt >= NSEG) begin
          o.status = ffsa_pkg::ST_FULL;
        end else begin
          if (rest != 0 && rest >= HDR) begin
            for (int k = seg_cnt; k > i + 1; k--) begin
              seg_start[k] = seg_start[k - 1];
              seg_used[k] = seg_used[k - 1];
            end
            seg_start[i + 1] = 32'(seg_start[i] + need);
            seg_used[i + 1] = 1'b0;
            seg_cnt++;
          end
          seg_used[i] = 1'b1;
          o.status = ffsa_pkg::ST_OK;
          o.granted = seg_start[i];
          o.data = 32'(seg_start[i] + 32'(HDR));
        end
      end
    end else begin
      for (i = 0; i < seg_cnt; i++) begin
        if (seg_used[i] && seg_start[i] == r.addr) begin
          hit = 1;
          break;
        end
      end
      if (!hit) begin
        o.status = ffsa_pkg::ST_BADH;
      end else begin
        seg_used[i] = 1'b0;
        if (i + 1 < seg_cnt && !seg_used[i + 1]) drop_entry(i + 1);
        if (i > 0 && !seg_used[i - 1]) drop_entry(i);
        o.granted = r.addr;
      end
    end
    return o;
  endfunction

  // Request driver: random gaps, mostly short and a few long.
  int gap = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (in_valid && in_ready) begin
      expected_rsps.push_back(predict_allocation(pending_reqs.pop_front()));
    end
    if (!in_valid || in_ready) begin
      if (gap > 0) begin
        gap <= gap - 1;
        in_valid <= 1'b0;
      end else if (rst_n && pending_reqs.size() > 0) begin
        alloc_req_t nx;
        nx = pending_reqs[0];
        in_valid <= 1'b1;
        in_cmd <= nx.cmd;
        in_request_size <= nx.size;
        in_block_address <= nx.addr;
        gap <= ($urandom_range(0, 9) < 6) ? 0 :
               (($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3));
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Long result stall, counted in its own process.
  always @(posedge clk) begin
    if (stall_start) stall_hold <= 300;
    else if (stall_hold > 0) stall_hold <= stall_hold - 1;
  end

  // Result monitor with random back pressure and one long hold-off.
  always @(posedge clk) begin
    if (out_valid && out_ready) begin
      alloc_rsp_t e;
      if (expected_rsps.size() == 0) begin
        $error("unexpected result status=%0d", out_status);
        errors = errors + 1;
      end else begin
        e = expected_rsps.pop_front();
        if (out_status !== e.status) begin
          $error("status: expected %0d, actual %0d", e.status, out_status);
          errors = errors + 1;
        end
        if (out_granted_address !== e.granted) begin
          $error("granted_address: expected %h, actual %h", e.granted, out_granted_address);
          errors = errors + 1;
        end
        if (out_data_start !== e.data) begin
          $error("data_start: expected %h, actual %h", e.data, out_data_start);
          errors = errors + 1;
        end
        if (e.status == ffsa_pkg::ST_OK && e.data != 0 && live_blocks.size() < 64)
          live_blocks.push_back(e.granted);
      end
    end
    if (stall_hold > 0) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= rst_n && ($urandom_range(0, 9) < 7 || $urandom_range(0, 29) == 0);
    end
  end

  always @(posedge clk) begin
    if (cycles >= CYCLE_LIMIT) begin
      $display("first_fit_segment_allocator_top: mismatch");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || in_valid || expected_rsps.size() != 0)
      @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] value);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= (idx == ffsa_pkg::REG_BASE) ? 3'd0 : 3'd4;
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    if (idx == ffsa_pkg::REG_BASE) mdl_base = value;
    else mdl_end = value;
    table_clear();
    live_blocks.delete();
    @(posedge clk);
  endtask

  function automatic void queue_req(logic cmd, logic [27:0] size, logic [31:0] addr);
    alloc_req_t r;
    r.cmd = cmd;
    r.size = size;
    r.addr = addr;
    pending_reqs.push_back(r);
  endfunction

  // Random allocations; frees mostly of earlier blocks, some random handles.
  task automatic random_phase(int n, int max_size);
    for (int k = 0; k < n; k++) begin
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        queue_req(ffsa_pkg::CMD_ALLOC, 28'($urandom_range(0, max_size)), $urandom);
      end else if (pick < 88 && live_blocks.size() > 0) begin
        int j;
        j = $urandom_range(0, live_blocks.size() - 1);
        queue_req(ffsa_pkg::CMD_FREE, 28'($urandom), live_blocks[j]);
        live_blocks.delete(j);
      end else if (pick < 94) begin
        queue_req(pick[0], 28'($urandom), $urandom);
      end else begin
        queue_req(ffsa_pkg::CMD_FREE, 28'($urandom),
                  32'(mdl_base + HDR * $urandom_range(0, 8)));
      end
      if (k % 40 == 39) wait_drained();
    end
    wait_drained();
  endtask

  initial begin
    mdl_base = ffsa_pkg::RESET_BASE;
    mdl_end = ffsa_pkg::RESET_END;
    table_clear();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed requests on the reset region.
    queue_req(ffsa_pkg::CMD_ALLOC, 28'd0, 32'd0);
    queue_req(ffsa_pkg::CMD_ALLOC, 28'd1, 32'hFFFF_FFFF);
    queue_req(ffsa_pkg::CMD_ALLOC, 28'd100, 32'd0);
    queue_req(ffsa_pkg::CMD_ALLOC, 28'hFFF_FFFF, 32'd0);
    queue_req(ffsa_pkg::CMD_FREE, 28'hFFF_FFFF, ffsa_pkg::RESET_BASE + 32'd16);
    queue_req(ffsa_pkg::CMD_FREE, 28'd0, ffsa_pkg::RESET_BASE);
    queue_req(ffsa_pkg::CMD_FREE, 28'd0, ffsa_pkg::RESET_BASE);
    queue_req(ffsa_pkg::CMD_FREE, 28'd0, 32'hFFFF_FFFF);
    queue_req(ffsa_pkg::CMD_FREE, 28'd0, ffsa_pkg::RESET_BASE + 32'd33);
    for (int k = 0; k < 16; k++) queue_req(ffsa_pkg::CMD_ALLOC, 28'd16, 32'd0);
    // Long result stall while requests keep coming.
    stall_start <= 1'b1;
    @(posedge clk);
    stall_start <= 1'b0;
    wait_drained();

    // Small region: exact fits and no-split leftovers.
    write_reg(ffsa_pkg::REG_BASE, 32'h0000_1000);
    write_reg(ffsa_pkg::REG_END, 32'h0000_1100);
    queue_req(ffsa_pkg::CMD_ALLOC, 28'd240, 32'd0);
    queue_req(ffsa_pkg::CMD_FREE, 28'd0, 32'h0000_1000);
    queue_req(ffsa_pkg::CMD_ALLOC, 28'd225, 32'd0);
    queue_req(ffsa_pkg::CMD_ALLOC, 28'd0, 32'd0);
    queue_req(ffsa_pkg::CMD_FREE, 28'd0, 32'h0000_1000);
    queue_req(ffsa_pkg::CMD_ALLOC, 28'd241, 32'd0);
    wait_drained();
    random_phase(300, 40);

    // Inverted region: every span counts as zero.
    write_reg(ffsa_pkg::REG_END, 32'h0000_0800);
    random_phase(50, 8);

    // Region at the top of the address space.
    write_reg(ffsa_pkg::REG_BASE, 32'hFFFF_FFF8);
    write_reg(ffsa_pkg::REG_END, 32'hFFFF_FFFF);
    queue_req(ffsa_pkg::CMD_ALLOC, 28'd0, 32'd0);
    wait_drained();
    write_reg(ffsa_pkg::REG_BASE, 32'hFFFF_F000);
    random_phase(300, 300);

    write_reg(ffsa_pkg::REG_BASE, 32'd0);
    write_reg(ffsa_pkg::REG_END, 32'hFFFF_FFFF);
    random_phase(300, 28'hFFF_FFFF);

    write_reg(ffsa_pkg::REG_BASE, 32'h0000_0000);
    write_reg(ffsa_pkg::REG_END, 32'h0000_0400);
    random_phase(270, 100);

    if (errors == 0) begin
      $display("first_fit_segment_allocator_top: match");
    end else begin
      $display("first_fit_segment_allocator_top: mismatch");
    end
    $finish;
  end
endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/ffsa_pkg.sv
hw/rtl/ffsa_ctrl.sv
hw/rtl/ffsa_dp.sv
hw/rtl/first_fit_segment_allocator_top.sv
test/first_fit_segment_allocator_top_tb.sv
